// ===== rtl/core/egcd_pkg.sv =====
// Package: widths, constants and sequencer states for the extended GCD core.
package egcd_pkg;
  localparam int WORD_COUNT_DEFAULT = 2;
  localparam int WORD_BITS = 32;
  localparam int OPND_W = 63;
  localparam int COEF_Y_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULX,
    ST_MULY,
    ST_FIX,
    ST_DONE
  } egcd_state_t;
endpackage

// ===== rtl/core/egcd_if.sv =====
// Interfaces: valid/ready channels for operands and results.
interface egcd_in_if (input logic clk);
  import egcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [OPND_W-1:0] operand_a;
  logic [OPND_W-1:0] operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink (input valid, operand_a, operand_b, output ready);
endinterface

interface egcd_out_if (input logic clk);
  import egcd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPND_W-1:0]          gcd_value;
  logic [OPND_W-1:0]          coef_x;
  logic signed [COEF_Y_W-1:0] coef_y;
  logic                       zero_error;
  modport source (output valid, gcd_value, coef_x, coef_y, zero_error, input ready);
  modport sink (input valid, gcd_value, coef_x, coef_y, zero_error, output ready);
endinterface

// ===== rtl/core/extended_gcd_bezout_core.sv =====
// Extended GCD core: one item at a time through a bit-serial divider and shift-add
// multiplier. Each Euclid iteration runs a division and then two multiply-subtracts,
// for the x and then the y coefficient, all on DW = 32*WORD_COUNT bits; up to about 92
// iterations per item. A zero operand goes straight to the result state with zero_error
// set and answers in the cycle after acceptance. Not ready from acceptance until the
// result is taken.
module extended_gcd_bezout_core
  import egcd_pkg::*;
#(
  parameter int WORD_COUNT = WORD_COUNT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  egcd_in_if.sink   in_ch,
  egcd_out_if.source out_ch
);
  localparam int DW = WORD_BITS * WORD_COUNT;
  localparam int CW = $clog2(DW + 1);

  egcd_state_t state, state_next;

  logic [DW-1:0] a, b;
  logic [DW-1:0] rem_prev, rem_cur, xcoef_prev, xcoef_cur, ycoef_prev, ycoef_cur;
  logic [DW-1:0] quotient_reg;
  logic [DW-1:0] part_rem, mul_acc, mul_q, mul_m;
  logic [CW-1:0] cnt;
  logic [DW-1:0] in_a, in_b;
  logic [DW:0]   shifted;
  logic          out_valid;
  logic [OPND_W-1:0] gcd_r, x_r;
  logic [DW-1:0] y_r;
  logic          err_r;

  assign in_a = DW'(in_ch.operand_a);
  assign in_b = DW'(in_ch.operand_b);
  assign shifted = {part_rem, quotient_reg[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid && in_ch.ready) begin
        state_next = (in_a == '0 || in_b == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV:  if (rem_cur == '0) state_next = ST_FIX;
               else if (cnt == CW'(DW)) state_next = ST_MULX;
      ST_MULX: if (cnt == CW'(DW)) state_next = ST_MULY;
      ST_MULY: if (cnt == CW'(DW)) state_next = ST_DIV;
      ST_FIX:  state_next = ST_DONE;
      ST_DONE: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_prev <= '0; rem_cur <= '0; xcoef_prev <= '0; xcoef_cur <= '0;
      ycoef_prev <= '0; ycoef_cur <= '0; quotient_reg <= '0; cnt <= '0;
      part_rem <= '0; mul_acc <= '0; mul_q <= '0; mul_m <= '0;
      err_r <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          a <= in_a; b <= in_b; cnt <= '0; part_rem <= '0;
          err_r <= (in_a == '0 || in_b == '0);
          if (in_a != '0 && in_b != '0) begin
            rem_prev <= in_a; rem_cur <= in_b; xcoef_prev <= DW'(1); xcoef_cur <= '0;
            ycoef_prev <= '0; ycoef_cur <= DW'(1); quotient_reg <= in_a;
          end
        end
        ST_DIV: if (rem_cur != '0) begin
          // restoring division: quotient_reg shifts dividend out, quotient in
          if (cnt == CW'(DW)) begin
            cnt <= '0; mul_acc <= '0; mul_q <= quotient_reg; mul_m <= xcoef_cur;
          end else begin
            cnt <= cnt + CW'(1);
            if (shifted >= {1'b0, rem_cur}) begin
              part_rem <= DW'(shifted - {1'b0, rem_cur});
              quotient_reg <= {quotient_reg[DW-2:0], 1'b1};
            end else begin
              part_rem <= shifted[DW-1:0];
              quotient_reg <= {quotient_reg[DW-2:0], 1'b0};
            end
          end
        end
        ST_MULX, ST_MULY: begin
          if (cnt == CW'(DW)) begin
            cnt <= '0;
            if (state == ST_MULX) begin
              xcoef_prev <= xcoef_cur; xcoef_cur <= xcoef_prev - mul_acc;
              mul_acc <= '0; mul_q <= quotient_reg; mul_m <= ycoef_cur;
            end else begin
              ycoef_prev <= ycoef_cur; ycoef_cur <= ycoef_prev - mul_acc;
              rem_prev <= rem_cur; rem_cur <= part_rem;
              quotient_reg <= rem_cur; part_rem <= '0;
            end
          end else begin
            cnt <= cnt + CW'(1);
            if (mul_q[0]) mul_acc <= mul_acc + mul_m;
            mul_q <= mul_q >> 1;
            mul_m <= mul_m << 1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      gcd_r <= '0; x_r <= '0; y_r <= '0;
    end else if (state == ST_FIX) begin
      gcd_r <= OPND_W'(rem_prev);
      if (xcoef_prev[DW-1]) begin
        x_r <= OPND_W'(xcoef_prev + b);
        y_r <= a - ycoef_prev;
      end else begin
        x_r <= OPND_W'(xcoef_prev);
        y_r <= '0 - ycoef_prev;
      end
    end
  end

  assign out_valid = (state == ST_DONE);
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.gcd_value = gcd_r;
  assign out_ch.coef_x = x_r;
  assign out_ch.coef_y = COEF_Y_W'(y_r);
  assign out_ch.zero_error = err_r;

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.zero_error) |-> (out_ch.gcd_value == '0 && out_ch.coef_x == '0))
    else $error("error result not zero");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DW)) else $error("counter overrun");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
`endif
endmodule
